### sv/zvc_pkg.sv
// Shared types and constants for the zigzag varint codec.
`default_nettype none
package zvc_pkg;

  localparam int VALUE_W      = 64;
  localparam int NARROW_W     = 32;
  localparam int BYTE_W       = 8;
  localparam int GROUP_W      = 7;
  localparam int WIDE_BYTES   = 10;
  localparam int NARROW_BYTES = 5;
  localparam int COUNT_W      = 4;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } enc_digit_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
  } dec_result_t;

endpackage
`default_nettype wire

### sv/zvc_if.sv
// Request and response channel interfaces of the zigzag varint codec.
`default_nettype none
interface zvc_req_if
  import zvc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               is_wide;
  logic               is_signed;
  logic [VALUE_W-1:0] value;
  logic [BYTE_W-1:0]  in_byte;

  modport source (output valid, req_type, is_wide, is_signed, value, in_byte, input ready);
  modport sink   (input valid, req_type, is_wide, is_signed, value, in_byte, output ready);
endinterface

interface zvc_rsp_if
  import zvc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [BYTE_W-1:0]  out_byte;
  logic [VALUE_W-1:0] out_value;
  logic               last;

  modport source (output valid, kind, out_byte, out_value, last, input ready);
  modport sink   (input valid, kind, out_byte, out_value, last, output ready);
endinterface
`default_nettype wire

### sv/zigzag_varint_codec_unit.sv
// Encode: transfer taken, then one byte a cycle into the output register while it is
// free; 1..5 bytes narrow or 1..10 wide, from 7-bit groups of the shift register.
// Decode: one byte transfer per cycle while no encode drains and the output is free;
// the value is in the output register the cycle after its final byte.
// Output register holds a result until taken. Reset (synchronous, active low) clears
// the decode accumulator and all valid state. Top level of the zigzag varint codec.
`default_nettype none
module zigzag_varint_codec_unit
  import zvc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  zvc_req_if.sink    in_req,
  zvc_rsp_if.source  out_rsp
);

  logic               out_free, accept, enc_load, enc_adv, dec_step, enc_busy;
  enc_digit_t         digit;
  dec_result_t        dres;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               last_r, last_nxt;

  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_req.ready = !enc_busy && out_free;
  assign accept       = in_req.valid && in_req.ready;
  assign enc_load     = accept && (in_req.req_type == REQ_ENCODE);
  assign dec_step     = accept && (in_req.req_type == REQ_DECODE);
  assign enc_adv      = enc_busy && out_free;

  zvc_encoder u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (enc_load),
    .is_wide   (in_req.is_wide),
    .is_signed (in_req.is_signed),
    .value     (in_req.value),
    .advance   (enc_adv),
    .busy      (enc_busy),
    .digit     (digit)
  );

  zvc_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (dec_step),
    .is_wide   (in_req.is_wide),
    .is_signed (in_req.is_signed),
    .in_byte   (in_req.in_byte),
    .result    (dres)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    if (out_free) begin
      out_valid_nxt = enc_adv || dres.done;
      if (enc_adv) begin
        kind_nxt  = KIND_BYTE;
        byte_nxt  = digit.data;
        value_nxt = '0;
        last_nxt  = digit.last;
      end else if (dres.done) begin
        kind_nxt  = KIND_VALUE;
        byte_nxt  = '0;
        value_nxt = dres.value;
        last_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.kind      = kind_r;
  assign out_rsp.out_byte  = byte_r;
  assign out_rsp.out_value = value_r;
  assign out_rsp.last      = last_r;

endmodule
`default_nettype wire

### sv/zvc_encoder.sv
// Zigzag mapping and 7-bit digit serializer for encode transfers.
`default_nettype none
module zvc_encoder
  import zvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               is_wide,
  input  wire logic               is_signed,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               advance,
  output      logic               busy,
  output      enc_digit_t         digit
);

  logic [VALUE_W-1:0] sr_r, sr_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [VALUE_W-1:0] mapped;
  logic               more;

  always_comb begin
    if (is_wide) begin
      mapped = is_signed ? ({value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{value[VALUE_W-1]}}) : value;
    end else begin
      mapped = {{(VALUE_W-NARROW_W){1'b0}},
                is_signed ? ({value[NARROW_W-2:0], 1'b0} ^ {NARROW_W{value[NARROW_W-1]}})
                          : value[NARROW_W-1:0]};
    end
  end

  always_comb begin
    more       = (|sr_r[VALUE_W-1:GROUP_W]) && (cnt_r != COUNT_W'(WIDE_BYTES-1));
    digit.last = !more;
    digit.data = more ? {1'b1, sr_r[GROUP_W-1:0]} : sr_r[BYTE_W-1:0];
  end

  always_comb begin
    sr_nxt   = sr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (load) begin
      sr_nxt   = mapped;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (advance && busy_r) begin
      if (more) begin
        sr_nxt  = {{GROUP_W{1'b0}}, sr_r[VALUE_W-1:GROUP_W]};
        cnt_nxt = cnt_r + COUNT_W'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

### sv/zvc_decoder.sv
// Group accumulator and zigzag unmapping for decode transfers.
`default_nettype none
module zvc_decoder
  import zvc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              is_wide,
  input  wire logic              is_signed,
  input  wire logic [BYTE_W-1:0] in_byte,
  output      dec_result_t       result
);

  localparam int EXT_W = GROUP_W * WIDE_BYTES;

  logic [VALUE_W-1:0] accum_r, accum_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               held_wide_r, held_wide_nxt;
  logic               held_signed_r, held_signed_nxt;
  logic               first, wide, sgn;
  logic [EXT_W-1:0]   ext;
  logic [VALUE_W-1:0] gathered;
  logic [COUNT_W-1:0] cnt_inc, limit;
  logic               done;

  always_comb begin
    first = (cnt_r == '0);
    wide  = first ? is_wide : held_wide_r;
    sgn   = first ? is_signed : held_signed_r;
    ext   = {(EXT_W-VALUE_W)'(0), (first ? {VALUE_W{1'b0}} : accum_r)};
    for (int k = 0; k < WIDE_BYTES; k++) begin
      if (cnt_r == COUNT_W'(k)) begin
        ext[GROUP_W*k +: GROUP_W] = ext[GROUP_W*k +: GROUP_W] | in_byte[GROUP_W-1:0];
      end
    end
    gathered = ext[VALUE_W-1:0];
    if (!wide) begin
      gathered[VALUE_W-1:NARROW_W] = '0;
    end
    cnt_inc = cnt_r + COUNT_W'(1);
    limit   = wide ? COUNT_W'(WIDE_BYTES) : COUNT_W'(NARROW_BYTES);
    done    = !in_byte[BYTE_W-1] || (cnt_inc >= limit);
  end

  always_comb begin
    result.done = step && done;
    if (!sgn) begin
      result.value = gathered;
    end else if (wide) begin
      result.value = {1'b0, gathered[VALUE_W-1:1]} ^ {VALUE_W{gathered[0]}};
    end else begin
      result.value = {{(VALUE_W-NARROW_W){1'b0}},
                      {1'b0, gathered[NARROW_W-1:1]} ^ {NARROW_W{gathered[0]}}};
    end
  end

  always_comb begin
    accum_nxt       = accum_r;
    cnt_nxt         = cnt_r;
    held_wide_nxt   = held_wide_r;
    held_signed_nxt = held_signed_r;
    if (step) begin
      held_wide_nxt   = wide;
      held_signed_nxt = sgn;
      if (done) begin
        accum_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        accum_nxt = gathered;
        cnt_nxt   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      cnt_r         <= '0;
      held_wide_r   <= 1'b0;
      held_signed_r <= 1'b0;
    end else begin
      accum_r       <= accum_nxt;
      cnt_r         <= cnt_nxt;
      held_wide_r   <= held_wide_nxt;
      held_signed_r <= held_signed_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/zvc_checker.sv
// Port-level assertions for the zigzag varint codec and their bind.
`default_nettype none
module zvc_checker
  import zvc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_req_type,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_kind,
  input wire logic [BYTE_W-1:0]  out_byte,
  input wire logic [VALUE_W-1:0] out_value,
  input wire logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_value))
    else $error("stalled result changed");

  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BYTE) |-> (out_byte[BYTE_W-1] == !out_last))
    else $error("continuation bit disagrees with last");

  a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_VALUE) |-> (out_byte == '0) && !out_last)
    else $error("decoded result carries byte fields");

  a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_ENCODE) |=> !in_ready)
    else $error("input taken while encode drains");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind zigzag_varint_codec_unit zvc_checker u_zvc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .in_req_type (in_req.req_type),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_kind    (out_rsp.kind),
  .out_byte    (out_rsp.out_byte),
  .out_value   (out_rsp.out_value),
  .out_last    (out_rsp.last)
);
`default_nettype wire
